// ===== hw/rtl/source_code_token_classifier_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the source code token classifier
// Concurrent checks on the rising edge of clk_i, off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SOURCE_CODE_TOKEN_CLASSIFIER_MACROS_SVH
`define SOURCE_CODE_TOKEN_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define SCTC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sctc check failed");
`define SCTC_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sctc check failed");
`define SCTC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sctc check failed");
`else
`define SCTC_ASSERT(name, prop)
`define SCTC_ASSERT_IMPLY(name, ante, cons)
`define SCTC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hw/rtl/sctc_pkg.sv =====
// ---------------------------------------------------------------------------
// sctc_pkg
// Types, character constants and the per-byte labelling function of the
// source code token classifier.
// ---------------------------------------------------------------------------
package sctc_pkg;

  typedef enum logic [2:0] {
    KIND_SPACE   = 3'd0,
    KIND_COMMENT = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_CHAR    = 3'd4,
    KIND_IDENT   = 3'd5,
    KIND_OTHER   = 3'd6,
    KIND_BLOCK   = 3'd7
  } kind_e;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [2:0] LenMax   = 3'd7;

  typedef struct packed {
    logic [7:0] prev;
    kind_e      kind;
    logic       in_tok;
    logic       dot;
    logic       esc;
    logic [2:0] len;
  } lex_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       first;
    logic       err;
    logic       last;
  } res_t;

  typedef struct packed {
    lex_t st;
    res_t res;
  } step_t;

  localparam lex_t LexClear = '{prev: 8'h00, kind: KIND_SPACE, in_tok: 1'b0,
                                dot: 1'b0, esc: 1'b0, len: 3'd0};

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alp(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Label byte x with lookahead n, starting from lexer state s.
  function automatic step_t lex_step(input lex_t s, input logic [7:0] x,
                                     input logic [7:0] n);
    step_t      o;
    lex_t       t;
    logic       joined;
    logic       err;
    logic [2:0] len;
    t      = s;
    joined = 1'b1;
    err    = 1'b0;
    len    = s.len;
    if (!s.in_tok) begin
      joined = 1'b0;
    end else begin
      case (s.kind)
        KIND_COMMENT: begin
          if (x == ChNl) joined = 1'b0;
        end
        KIND_BLOCK: begin
          if (x == ChNul) joined = 1'b0;
          else if (len >= 3'd3 && s.prev == ChStar && x == ChSlash) t.in_tok = 1'b0;
        end
        KIND_NUMBER: begin
          if (is_dig(x)) begin
          end else if (x == ChDot && !s.dot) begin
            t.dot = 1'b1;
          end else begin
            joined = 1'b0;
          end
        end
        KIND_STRING: begin
          if (s.esc && x == ChDquote) begin
            t.esc = 1'b0;
          end else begin
            t.esc = 1'b0;
            if (x == ChNul) err = 1'b1;
            else if (x == ChDquote) t.in_tok = 1'b0;
            else if (x == ChBslash) t.esc = 1'b1;
          end
        end
        KIND_CHAR: begin
          if (s.esc || x == ChQuote) t.in_tok = 1'b0;
          else if (is_ws(x) && n != ChQuote) err = 1'b1;
          else if (x == ChNul) err = 1'b1;
          else if (len == 3'd2 && s.prev == ChBslash && x != ChBslash) t.esc = 1'b1;
          else if (len > 3'd1 && s.prev != ChBslash && (n == ChQuote || n == ChBslash))
            err = 1'b1;
        end
        KIND_IDENT: begin
          if (!(is_alp(x) || is_dig(x) || x == ChUnder)) joined = 1'b0;
        end
        default: joined = 1'b0;
      endcase
    end
    if (!joined) begin
      t.in_tok = 1'b1;
      t.dot    = 1'b0;
      t.esc    = 1'b0;
      t.len    = 3'd1;
      if (is_ws(x)) begin
        t.kind   = KIND_SPACE;
        t.in_tok = 1'b0;
      end else if (x == ChSlash && n == ChSlash) begin
        t.kind = KIND_COMMENT;
      end else if (x == ChSlash && n == ChStar) begin
        t.kind = KIND_BLOCK;
      end else if (is_dig(x)) begin
        t.kind = KIND_NUMBER;
      end else if (x == ChDquote) begin
        t.kind = KIND_STRING;
      end else if (x == ChQuote) begin
        t.kind = KIND_CHAR;
      end else if (is_alp(x)) begin
        t.kind = KIND_IDENT;
      end else begin
        t.kind   = KIND_OTHER;
        t.in_tok = 1'b0;
      end
    end else if (len < LenMax) begin
      t.len = len + 3'd1;
    end
    t.prev      = x;
    o.st        = t;
    o.res.data  = x;
    o.res.kind  = (t.kind == KIND_BLOCK) ? KIND_COMMENT : t.kind;
    o.res.first = !joined;
    o.res.err   = err;
    o.res.last  = err;
    return o;
  endfunction

endpackage

// ===== hw/rtl/source_code_token_classifier.sv =====
// ---------------------------------------------------------------------------
// source_code_token_classifier
// Labels each byte of source text with its token kind and a token-start mark;
// after a lexing error, bytes up to the end of that text are dropped.
// Channel  Dir  Handshake              Payload
// in       in   in_valid_i/in_ready_o  data_byte_i, is_last_i
// out      out  out_valid_o/out_ready_i out_byte_o, token_kind_o, token_first_o,
//                                      lex_error_o, stream_end_o
//
// One byte is accepted per cycle; each byte is labelled when the next one
// arrives, and results leave from a three-entry output queue.
// A final byte with a held byte yields two results in the same cycle.
// in_ready_o is low while the queue holds two or more results.
// Reset clears the lexer, the held byte and the queue; no clearing pass.
// ---------------------------------------------------------------------------
module source_code_token_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] token_kind_o,
  output logic       token_first_o,
  output logic       lex_error_o,
  output logic       stream_end_o
);
  import sctc_pkg::*;
  `include "source_code_token_classifier_macros.svh"

  localparam int unsigned QDepth = 3;

  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  lex_t       lex_q, lex_d;
  logic       stop_q, stop_d;

  res_t       ent_q [QDepth];
  res_t       ent_d [QDepth];
  logic [1:0] cnt_q, cnt_d;

  logic       acc, pop;
  logic       push0, push1;
  res_t       res0, res1;
  step_t      step_a, step_b;

  assign in_ready_o = (cnt_q <= 2'd1);
  assign acc        = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;

  // Held byte with the new byte as lookahead, then the new byte itself at end of text.
  assign step_a = lex_step(lex_q, held_q, data_byte_i);
  assign step_b = lex_step(held_vld_q ? step_a.st : lex_q, data_byte_i, ChNul);

  always_comb begin
    held_d     = held_q;
    held_vld_d = held_vld_q;
    lex_d      = lex_q;
    stop_d     = stop_q;
    push0      = 1'b0;
    push1      = 1'b0;
    res0       = step_a.res;
    res1       = step_b.res;
    res1.last  = 1'b1;
    if (acc) begin
      if (stop_q) begin
        // drop bytes until the end of the broken text
        if (is_last_i) begin
          stop_d     = 1'b0;
          held_vld_d = 1'b0;
          lex_d      = LexClear;
        end
      end else if (held_vld_q && step_a.res.err) begin
        push0      = 1'b1;
        held_vld_d = 1'b0;
        lex_d      = LexClear;
        stop_d     = !is_last_i;
      end else if (is_last_i) begin
        if (held_vld_q) begin
          push0 = 1'b1;
          push1 = 1'b1;
        end else begin
          push0 = 1'b1;
          res0  = res1;
        end
        held_vld_d = 1'b0;
        held_d     = 8'h00;
        lex_d      = LexClear;
      end else begin
        push0      = held_vld_q;
        held_d     = data_byte_i;
        held_vld_d = 1'b1;
        if (held_vld_q) lex_d = step_a.st;
      end
    end
  end

  // Output queue: head at entry 0, shift on pop, append behind the tail.
  always_comb begin
    logic [1:0] base;
    base = cnt_q - {1'b0, pop};
    for (int unsigned i = 0; i < QDepth; i++) begin
      if (pop && i < QDepth - 1) ent_d[i] = ent_q[i + 1];
      else                       ent_d[i] = ent_q[i];
      if (push0 && base == i[1:0]) ent_d[i] = res0;
      if (push1 && base + 2'd1 == i[1:0]) ent_d[i] = res1;
    end
    cnt_d = base + {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q <= 1'b0;
      lex_q      <= LexClear;
      stop_q     <= 1'b0;
      cnt_q      <= 2'd0;
      held_q     <= 8'h00;
    end else begin
      held_vld_q <= held_vld_d;
      lex_q      <= lex_d;
      stop_q     <= stop_d;
      cnt_q      <= cnt_d;
      held_q     <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < QDepth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign out_byte_o    = ent_q[0].data;
  assign token_kind_o  = ent_q[0].kind;
  assign token_first_o = ent_q[0].first;
  assign lex_error_o   = ent_q[0].err;
  assign stream_end_o  = ent_q[0].last;

  `SCTC_ASSERT_IMPLY(a_stop_silent, acc && stop_q, !push0 && !push1)
  `SCTC_ASSERT_IMPLY(a_pair_order, push1, push0)
  `SCTC_ASSERT_NEXT(a_last_drains, acc && is_last_i, !held_vld_q)
  `SCTC_ASSERT_IMPLY(a_err_ends, out_valid_o && lex_error_o, stream_end_o)
  `SCTC_ASSERT(a_no_overflow, !(push1 && cnt_q == 2'd2 && !pop))

endmodule
